FILE: rtl/ofrs_pkg.sv
// Shared types, constants and a popcount helper function for the OneMax roulette selector.
package ofrs_pkg;

    localparam int POP_MAX     = 256;
    localparam int GENE_BITS   = 32;
    localparam int IDX_W       = 8;
    localparam int FIT_W       = 6;
    localparam int TOT_W       = 14;
    localparam int RND_W       = 16;
    localparam int CNT_W       = 9;
    localparam int BYTES       = GENE_BITS / 8;
    localparam int BYTE_IDX_W  = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int DIV_CNT_W   = $clog2(RND_W);
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    localparam logic OP_EVAL   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] slot;
        logic [31:0]      gene;
        logic [RND_W-1:0] random_value;
    } t_in;

    typedef struct packed {
        logic [FIT_W-1:0] fitness;
        logic [IDX_W-1:0] best_slot;
        logic [FIT_W-1:0] best_fitness;
        logic [IDX_W-1:0] worst_slot;
        logic [FIT_W-1:0] worst_fitness;
        logic [TOT_W-1:0] fitness_total;
        logic [IDX_W-1:0] chosen_slot;
        logic [31:0]      chosen_gene;
        logic             select_error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_POP,
        S_UPD,
        S_DIV,
        S_SCAN,
        S_GRD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic pop_step;
        logic upd;
        logic div_step;
        logic scan_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op_select;
        logic total_zero;
        logic pop_last;
        logic div_last;
        logic scan_done;
    } t_sts;

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

endpackage

FILE: rtl/ofrs_ctrl.sv
// Controller state machine sequencing evaluate and select transactions.
module ofrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ofrs_pkg::t_sts i_sts,
    output ofrs_pkg::t_cmd o_cmd
);

    ofrs_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ofrs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ofrs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ofrs_pkg::S_DISP;
                end
            end
            ofrs_pkg::S_DISP: begin
                if (!i_sts.op_select) begin
                    n_state = ofrs_pkg::S_POP;
                end else if (i_sts.total_zero) begin
                    n_state = ofrs_pkg::S_DONE;
                end else begin
                    n_state = ofrs_pkg::S_DIV;
                end
            end
            ofrs_pkg::S_POP: begin
                o_cmd.pop_step = 1'b1;
                if (i_sts.pop_last) begin
                    n_state = ofrs_pkg::S_UPD;
                end
            end
            ofrs_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ofrs_pkg::S_DONE;
            end
            ofrs_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ofrs_pkg::S_SCAN;
                end
            end
            ofrs_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ofrs_pkg::S_GRD;
                end
            end
            ofrs_pkg::S_GRD: begin
                n_state = ofrs_pkg::S_DONE;
            end
            ofrs_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ofrs_pkg::S_IDLE;
                end
            end
            default: n_state = ofrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/ofrs_dp.sv
// Datapath: gene and fitness stores, popcount, statistics, modulo unit and wheel scan.
module ofrs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ofrs_pkg::t_cmd               i_cmd,
    output ofrs_pkg::t_sts               o_sts,
    input  ofrs_pkg::t_in                i_in,
    input  logic                         i_cfg_we,
    input  logic [ofrs_pkg::CNT_W-1:0]   i_cfg_data,
    output ofrs_pkg::t_out               o_out
);

    logic [31:0]                        gene_mem [ofrs_pkg::POP_MAX];
    logic [ofrs_pkg::FIT_W-1:0]         fit_mem  [ofrs_pkg::POP_MAX];

    logic [ofrs_pkg::CNT_W-1:0]         r_pop_count;
    logic                               r_op;
    logic [ofrs_pkg::IDX_W-1:0]         r_slot;
    logic [31:0]                        r_gene;
    logic [ofrs_pkg::RND_W-1:0]         r_rnd_sh;
    logic [ofrs_pkg::TOT_W-1:0]         r_rem;
    logic [ofrs_pkg::DIV_CNT_W-1:0]     r_div_cnt;
    logic [ofrs_pkg::BYTE_IDX_W-1:0]    r_byte_idx;
    logic [ofrs_pkg::FIT_W-1:0]         r_fit;
    logic [ofrs_pkg::IDX_W-1:0]         r_best_idx, r_worst_idx;
    logic [ofrs_pkg::FIT_W-1:0]         r_best_fit, r_worst_fit;
    logic [ofrs_pkg::TOT_W-1:0]         r_total, n_total;
    logic [ofrs_pkg::TOT_W-1:0]         r_sum;
    logic [ofrs_pkg::IDX_W-1:0]         r_idx;
    logic [ofrs_pkg::IDX_W-1:0]         r_chosen;
    logic [ofrs_pkg::FIT_W-1:0]         r_fit_q;
    logic [31:0]                        r_gene_q;
    ofrs_pkg::t_out                     r_out, n_out;

    logic [ofrs_pkg::CNT_W-1:0]         w_count;
    logic [ofrs_pkg::CNT_W-1:0]         w_last_full;
    logic [ofrs_pkg::IDX_W-1:0]         w_last;
    logic [7:0]                         w_byte;
    logic [ofrs_pkg::TOT_W:0]           w_tot_sum;
    logic [ofrs_pkg::TOT_W:0]           w_trial;
    logic [ofrs_pkg::TOT_W:0]           w_diff;
    logic [ofrs_pkg::TOT_W-1:0]         w_sum_n;
    logic                               w_hit;
    logic                               w_scan_done;
    logic [ofrs_pkg::IDX_W-1:0]         w_rd_addr;
    logic                               w_in_count;
    logic                               w_in_store;

    always_comb begin
        if (r_pop_count == '0) begin
            w_count = ofrs_pkg::CNT_W'(1);
        end else if (r_pop_count > ofrs_pkg::CNT_W'(ofrs_pkg::POP_MAX)) begin
            w_count = ofrs_pkg::CNT_W'(ofrs_pkg::POP_MAX);
        end else begin
            w_count = r_pop_count;
        end
    end

    assign w_last_full = w_count - ofrs_pkg::CNT_W'(1);
    assign w_last      = w_last_full[ofrs_pkg::IDX_W-1:0];
    assign w_byte      = r_gene[{r_byte_idx, 3'b000} +: 8];
    assign w_in_count  = {1'b0, r_slot} < w_count;
    assign w_in_store  = {1'b0, r_slot} < ofrs_pkg::CNT_W'(ofrs_pkg::POP_MAX);

    assign w_tot_sum = {1'b0, r_total} + (ofrs_pkg::TOT_W+1)'(r_fit);
    assign n_total   = (w_tot_sum > {1'b0, ofrs_pkg::TOTAL_MAX}) ? ofrs_pkg::TOTAL_MAX
                                                               : w_tot_sum[ofrs_pkg::TOT_W-1:0];

    assign w_trial = {r_rem, r_rnd_sh[ofrs_pkg::RND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_total};

    assign w_sum_n     = r_sum + ofrs_pkg::TOT_W'(r_fit_q);
    assign w_hit       = w_sum_n > r_rem;
    assign w_scan_done = w_hit || (r_idx == w_last);
    assign w_rd_addr   = i_cmd.scan_step ? r_idx + ofrs_pkg::IDX_W'(1) : r_idx;

    assign o_sts.op_select  = (r_op == ofrs_pkg::OP_SELECT);
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.pop_last   = (r_byte_idx == ofrs_pkg::BYTE_IDX_W'(ofrs_pkg::BYTES - 1));
    assign o_sts.div_last   = (r_div_cnt == ofrs_pkg::DIV_CNT_W'(ofrs_pkg::RND_W - 1));
    assign o_sts.scan_done  = w_scan_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && w_in_store) begin
            gene_mem[r_slot] <= r_gene;
            fit_mem[r_slot]  <= r_fit;
        end
        r_fit_q  <= fit_mem[w_rd_addr];
        r_gene_q <= gene_mem[r_chosen];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_count <= ofrs_pkg::CNT_W'(ofrs_pkg::POP_MAX);
        end else if (i_cfg_we) begin
            r_pop_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_idx  <= '0;
            r_best_fit  <= '0;
            r_worst_idx <= '0;
            r_worst_fit <= '0;
            r_total     <= '0;
        end else if (i_cmd.upd && w_in_store) begin
            if (r_slot == '0) begin
                r_best_idx  <= '0;
                r_worst_idx <= '0;
                r_best_fit  <= r_fit;
                r_worst_fit <= r_fit;
                r_total     <= ofrs_pkg::TOT_W'(r_fit);
            end else if (w_in_count) begin
                if (r_fit > r_best_fit) begin
                    r_best_fit <= r_fit;
                    r_best_idx <= r_slot;
                end
                if (r_fit < r_worst_fit) begin
                    r_worst_fit <= r_fit;
                    r_worst_idx <= r_slot;
                end
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_in.op;
            r_slot     <= i_in.slot;
            r_gene     <= i_in.gene;
            r_rnd_sh   <= i_in.random_value;
            r_rem      <= '0;
            r_div_cnt  <= '0;
            r_byte_idx <= '0;
            r_fit      <= '0;
            r_sum      <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cmd.pop_step) begin
                r_fit      <= r_fit + ofrs_pkg::FIT_W'(ofrs_pkg::pop8(w_byte));
                r_byte_idx <= r_byte_idx + ofrs_pkg::BYTE_IDX_W'(1);
            end
            if (i_cmd.div_step) begin
                if (w_trial >= {1'b0, r_total}) begin
                    r_rem <= w_diff[ofrs_pkg::TOT_W-1:0];
                end else begin
                    r_rem <= w_trial[ofrs_pkg::TOT_W-1:0];
                end
                r_rnd_sh  <= r_rnd_sh << 1;
                r_div_cnt <= r_div_cnt + ofrs_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.scan_step) begin
                r_sum <= w_sum_n;
                r_idx <= r_idx + ofrs_pkg::IDX_W'(1);
                if (w_scan_done) begin
                    r_chosen <= r_idx;
                end
            end
        end
    end

    always_comb begin
        n_out               = '0;
        n_out.best_slot     = r_best_idx;
        n_out.best_fitness  = r_best_fit;
        n_out.worst_slot    = r_worst_idx;
        n_out.worst_fitness = r_worst_fit;
        n_out.fitness_total = r_total;
        if (r_op == ofrs_pkg::OP_EVAL) begin
            n_out.fitness = r_fit;
        end else if (r_total == '0) begin
            n_out.select_error = 1'b1;
        end else begin
            n_out.chosen_slot = r_chosen;
            n_out.chosen_gene = r_gene_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

FILE: rtl/onemax_fitness_roulette_select.sv
// Top level: OneMax fitness evaluator with roulette wheel parent selection.
// Evaluate: popcount of the gene one byte at a time, then store and statistics update.
// Select: bit-serial modulo of the random value by the fitness total, then a walk over
//   k = 1..population_count wheel entries, one fitness store read per cycle.
// Zero total select: no modulo or wheel walk, select_error is set. One transaction at a time.
// Reset: statistics zero, population_count 256; gene and fitness stores not cleared.
module onemax_fitness_roulette_select (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ofrs_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ofrs_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic [ofrs_pkg::CNT_W-1:0] i_cfg_data
);

    ofrs_pkg::t_cmd w_cmd;
    ofrs_pkg::t_sts w_sts;

    ofrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ofrs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

    a_err_clears_choice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.select_error |->
            o_out.chosen_slot == '0 && o_out.chosen_gene == '0)
        else $error("select error with nonzero choice");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_best_not_below_worst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.best_fitness >= o_out.worst_fitness)
        else $error("best fitness below worst fitness");

    a_fitness_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.fitness <= ofrs_pkg::FIT_W'(ofrs_pkg::GENE_BITS))
        else $error("fitness above gene width");

endmodule

FILE: tb/tb_onemax_fitness_roulette_select.sv
// Testbench for the OneMax roulette selector: queued transactions checked against a predictor.
`timescale 1ns / 100ps

module tb_onemax_fitness_roulette_select;
    import ofrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned GAP_PCT     = 13;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in              in_item   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_stats;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;

    t_in              gene_items[$];
    t_out             stats_due[$];
    bit               no_gaps    = 1'b0;
    int unsigned      mismatches = 0;
    int unsigned      cycle_cnt  = 0;

    logic [31:0]      gene_mem[POP_MAX];
    logic [FIT_W-1:0] fit_mem[POP_MAX];
    bit               written[POP_MAX];
    logic [IDX_W-1:0] best_idx    = '0;
    logic [FIT_W-1:0] best_fit    = '0;
    logic [IDX_W-1:0] worst_idx   = '0;
    logic [FIT_W-1:0] worst_fit   = '0;
    int unsigned      model_total = 0;
    logic [CNT_W-1:0] pop_cfg     = 9'd256;

    onemax_fitness_roulette_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_stats),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic int unsigned live_count();
        if (pop_cfg == 0) return 1;
        if (pop_cfg > POP_MAX) return POP_MAX;
        return 32'(pop_cfg);
    endfunction

    function automatic void spin_wheel(input logic [RND_W-1:0] rnd,
                                       output logic [IDX_W-1:0] pick, output bit clean);
        int unsigned n;
        int unsigned draw;
        int unsigned acc;
        bit          found;
        n     = live_count();
        pick  = IDX_W'(n - 1);
        clean = 1'b1;
        acc   = 0;
        found = 1'b0;
        if (model_total != 0) begin
            draw = 32'(rnd) % model_total;
            for (int i = 0; i < n; i++) begin
                if (!found) begin
                    clean = clean & written[i];
                    acc   = acc + 32'(fit_mem[i]);
                    if (acc > draw) begin
                        found = 1'b1;
                        pick  = IDX_W'(i);
                    end
                end
            end
            clean = clean & written[pick];
        end
    endfunction

    function automatic void onemax_step(input t_in it);
        t_out             r;
        int unsigned      n;
        int unsigned      fit;
        logic [IDX_W-1:0] pick;
        bit               clean;
        r = '0;
        n = live_count();
        if (it.op == OP_EVAL) begin
            fit       = $countones(it.gene);
            r.fitness = FIT_W'(fit);
            gene_mem[it.slot] = it.gene;
            fit_mem[it.slot]  = FIT_W'(fit);
            written[it.slot]  = 1'b1;
            if (it.slot == 0) begin
                best_idx    = '0;
                worst_idx   = '0;
                best_fit    = FIT_W'(fit);
                worst_fit   = FIT_W'(fit);
                model_total = fit;
            end else if (it.slot < n) begin
                if (fit > best_fit) begin
                    best_fit = FIT_W'(fit);
                    best_idx = it.slot;
                end
                if (fit < worst_fit) begin
                    worst_fit = FIT_W'(fit);
                    worst_idx = it.slot;
                end
                model_total = model_total + fit;
                if (model_total > TOTAL_MAX) model_total = 32'(TOTAL_MAX);
            end
        end else if (model_total == 0) begin
            r.select_error = 1'b1;
        end else begin
            spin_wheel(it.random_value, pick, clean);
            r.chosen_slot = pick;
            r.chosen_gene = gene_mem[pick];
        end
        r.best_slot     = best_idx;
        r.best_fitness  = best_fit;
        r.worst_slot    = worst_idx;
        r.worst_fitness = worst_fit;
        r.fitness_total = TOT_W'(model_total);
        stats_due.push_back(r);
    endfunction

    function automatic void add_eval(input logic [IDX_W-1:0] slot, input logic [31:0] gene);
        t_in it;
        it.op           = OP_EVAL;
        it.slot         = slot;
        it.gene         = gene;
        it.random_value = RND_W'($urandom);
        gene_items.push_back(it);
        onemax_step(it);
    endfunction

    // retry with fresh draws so the wheel never touches a slot never stored
    function automatic void add_select(input logic [RND_W-1:0] rnd);
        t_in              it;
        logic [IDX_W-1:0] pick;
        bit               clean;
        int               tries;
        it.op           = OP_SELECT;
        it.slot         = IDX_W'($urandom);
        it.gene         = $urandom;
        it.random_value = rnd;
        tries           = 0;
        spin_wheel(it.random_value, pick, clean);
        while (!clean && tries < 8) begin
            it.random_value = RND_W'($urandom);
            spin_wheel(it.random_value, pick, clean);
            tries++;
        end
        if (clean) begin
            gene_items.push_back(it);
            onemax_step(it);
        end
    endfunction

    function automatic logic [31:0] pick_gene();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            4: return $urandom & $urandom & $urandom;
            5: return $urandom | $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic settle();
        @(negedge i_clk);
        while (gene_items.size() != 0 || in_valid || stats_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_population(input logic [CNT_W-1:0] value);
        settle();
        no_gaps = 1'b0;
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        pop_cfg = value;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] value, input int items,
                                input bit steady);
        int unsigned n;
        int unsigned roll;
        set_population(value);
        no_gaps = steady;
        n = live_count();
        if ($urandom_range(4) != 0) add_eval(0, pick_gene());
        for (int k = 0; k < items; k++) begin
            roll = $urandom_range(99);
            if (roll < 5) add_select(RND_W'($urandom_range(15)));
            else if (roll < 35) add_select(RND_W'($urandom));
            else if (roll < 40) add_eval(0, pick_gene());
            else if (roll < 50 || n < 2) add_eval(IDX_W'($urandom_range(255)), pick_gene());
            else add_eval(IDX_W'($urandom_range(n - 1, 1)), pick_gene());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (gene_items.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                in_valid <= 1'b1;
                in_item  <= gene_items.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
            if (out_valid && out_ready) begin
                if (stats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result transaction with none outstanding");
                end else begin
                    want = stats_due.pop_front();
                    check_field("fitness", 32'(want.fitness), 32'(out_stats.fitness));
                    check_field("best_slot", 32'(want.best_slot), 32'(out_stats.best_slot));
                    check_field("best_fitness", 32'(want.best_fitness),
                                32'(out_stats.best_fitness));
                    check_field("worst_slot", 32'(want.worst_slot), 32'(out_stats.worst_slot));
                    check_field("worst_fitness", 32'(want.worst_fitness),
                                32'(out_stats.worst_fitness));
                    check_field("fitness_total", 32'(want.fitness_total),
                                32'(out_stats.fitness_total));
                    check_field("chosen_slot", 32'(want.chosen_slot),
                                32'(out_stats.chosen_slot));
                    check_field("chosen_gene", want.chosen_gene, out_stats.chosen_gene);
                    check_field("select_error", 32'(want.select_error),
                                32'(out_stats.select_error));
                end
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("** onemax_fitness_roulette_select: FAILED **");
        $finish;
    end

    initial begin
        for (int i = 0; i < POP_MAX; i++) written[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero total, statistics before any restart, ties, extremes
        add_select(16'h1234);
        add_eval(5, 32'h0000000F);
        add_eval(0, '1);
        add_eval(1, '0);
        add_eval(2, 32'h0000FFFF);
        add_eval(3, '1);
        add_eval(4, '0);
        add_eval(255, 32'h80000001);
        add_select(16'h0000);
        add_select(16'hFFFF);
        add_select(16'd47);

        // single individual, slot outside the count
        set_population(9'd1);
        add_eval(0, 32'hAAAAAAAA);
        add_eval(1, 32'h55555555);
        add_select(16'd7);

        // stale total: wheel runs out on the last counted slot
        set_population(9'd2);
        add_eval(1, 32'hFFFF0000);
        set_population(9'd0);
        add_eval(1, '0);
        set_population(9'd2);
        add_select(16'd20);
        add_select(16'd3);
        set_population(9'd256);
        add_select(16'd25);

        // fill every slot, then mix updates and draws over the full wheel
        set_population(9'd511);
        add_eval(0, '1);
        for (int s = 1; s < POP_MAX; s++)
            add_eval(IDX_W'(s), ($urandom_range(3) == 0) ? pick_gene() : '1);
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 0) add_eval(IDX_W'($urandom_range(255, 1)), pick_gene());
            else add_select(RND_W'($urandom));
        end

        random_phase(9'd256, 40, 1'b1);
        random_phase(9'd2, 15, 1'b0);
        random_phase(9'd37, 15, 1'b0);
        random_phase(9'd1, 15, 1'b0);
        random_phase(9'd200, 15, 1'b0);
        random_phase(9'd128, 15, 1'b0);
        random_phase(CNT_W'($urandom_range(255, 3)), 15, 1'b0);
        random_phase(9'd300, 15, 1'b0);

        settle();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && stats_due.size() == 0)
            $display("** onemax_fitness_roulette_select: PASSED **");
        else
            $display("** onemax_fitness_roulette_select: FAILED **");
        $finish;
    end

endmodule
